// ===== hdl/crc_cwb_pkg.sv =====
package crc_cwb_pkg;

   localparam int CRC_W     = 16;
   localparam int BYTE_W    = 8;
   localparam int CWIDTH_W  = 5;
   localparam int SHIFT_W   = 4;
   localparam int CSR_IDX_W = 4;

   localparam logic [CWIDTH_W-1:0] CRC_MIN_WIDTH = 5'd8;
   localparam logic [CWIDTH_W-1:0] CRC_MAX_WIDTH = 5'd16;
   localparam logic [CRC_W-1:0]    POLY_RESET    = 16'h0000;
   localparam logic [CWIDTH_W-1:0] WIDTH_RESET   = 5'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_POLY_IDX  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IDX = 4'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic [CRC_W-1:0]  seed_value;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [CRC_W-1:0] crc_value;
      logic             done_res;
   } rsp_type;

   // settings handed from the register block to the datapath
   typedef struct packed {
      logic [CRC_W-1:0]   crc_poly;
      logic [SHIFT_W-1:0] crc_shift;   // 16 minus the clamped width
   } cfg_type;

endpackage

// ===== hdl/crc_cwb_csr.sv =====
module crc_cwb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [crc_cwb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crc_cwb_pkg::CRC_W-1:0]  csr_data,
   output crc_cwb_pkg::cfg_type           cfg
);
   import crc_cwb_pkg::*;

   logic [CRC_W-1:0]    poly_ff, poly_in;
   logic [CWIDTH_W-1:0] width_ff, width_in;
   logic [CWIDTH_W-1:0] width_clamped;
   logic [CWIDTH_W-1:0] shift_full;

   assign csr_ready = 1'b1;

   always_comb begin
      poly_in  = poly_ff;
      width_in = width_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POLY_IDX:  poly_in  = csr_data;
            CSR_WIDTH_IDX: width_in = csr_data[CWIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff  <= POLY_RESET;
         width_ff <= WIDTH_RESET;
      end else begin
         poly_ff  <= poly_in;
         width_ff <= width_in;
      end
   end

   always_comb begin
      priority if (width_ff < CRC_MIN_WIDTH) begin
         width_clamped = CRC_MIN_WIDTH;
      end else if (width_ff > CRC_MAX_WIDTH) begin
         width_clamped = CRC_MAX_WIDTH;
      end else begin
         width_clamped = width_ff;
      end
      shift_full = CRC_MAX_WIDTH - width_clamped;
   end

   assign cfg.crc_poly  = poly_ff;
   assign cfg.crc_shift = shift_full[SHIFT_W-1:0];

endmodule

// ===== hdl/crc_cwb_step.sv =====
module crc_cwb_step (
   input  crc_cwb_pkg::cfg_type              cfg,
   input  logic [crc_cwb_pkg::CRC_W-1:0]     crc_in,
   input  logic [crc_cwb_pkg::BYTE_W-1:0]    data_byte,
   output logic [crc_cwb_pkg::CRC_W-1:0]     crc_out
);
   import crc_cwb_pkg::*;

   logic [CRC_W-1:0] poly_top;
   logic [CRC_W-1:0] acc;

   // work left-aligned in 16 bits: the left shift drops bits above the width
   always_comb begin
      poly_top = cfg.crc_poly << cfg.crc_shift;
      acc      = (crc_in << cfg.crc_shift) ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         acc = {acc[CRC_W-2:0], 1'b0} ^ (acc[CRC_W-1] ? poly_top : '0);
      end
      crc_out = acc >> cfg.crc_shift;
   end

endmodule

// ===== hdl/crc_configurable_width_byte.sv =====
// channel  | direction | handshake           | payload
// req      | in        | req_valid/req_stall | req_data  (crc_cwb_pkg::req_type)
// rsp      | out       | rsp_valid/rsp_stall | rsp_data  (crc_cwb_pkg::rsp_type)
// csr      | in        | csr_valid/csr_ready | csr_index, csr_data
//
// one byte per cycle sustained while rsp_stall is low; a byte reaches rsp after its transfer through
// the input register at the transfer, then the eight-step xor network into the result register
// synchronous active-high reset empties both registers and loads the default settings
// a stalled result holds the result register; the input register still fills,
// so req_stall rises only when both registers are full and rsp_stall is high
module crc_configurable_width_byte (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  crc_cwb_pkg::req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output crc_cwb_pkg::rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [crc_cwb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [crc_cwb_pkg::CRC_W-1:0]     csr_data
);
   import crc_cwb_pkg::*;

   cfg_type          cfg;
   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff;
   logic [CRC_W-1:0] running_ff;
   logic [CRC_W-1:0] crc_start;
   logic [CRC_W-1:0] crc_next;
   logic             advance;
   logic             req_xfer;

   crc_cwb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign crc_start = in_data_ff.first_byte ? in_data_ff.seed_value : running_ff;

   crc_cwb_step u_step (
      .cfg       (cfg),
      .crc_in    (crc_start),
      .data_byte (in_data_ff.data_byte),
      .crc_out   (crc_next)
   );

   // the input register moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         running_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            running_ff <= crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.crc_value <= crc_next;
         out_data_ff.done_res  <= in_data_ff.last_byte;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hdl/crc_cwb_checker.sv =====
module crc_cwb_props (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input crc_cwb_pkg::rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // nothing comes out straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // a result transfer always frees room for a new byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> !req_stall)
      else $error("input stalled during result transfer");

endmodule

bind crc_configurable_width_byte crc_cwb_props u_crc_cwb_props (.*);
